### src/tterm_pkg.sv
// Package for the text terminal: shared types, character codes and colour constants.
// No dependencies; tterm_esc, tterm_seq and the top level import it.
package tterm_pkg;

   // Fixed widths of the result ports
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int CELL_W     = 16;

   // Stream characters
   localparam logic [7:0] KEY_NEWLINE  = 8'h0A;
   localparam logic [7:0] KEY_ESC      = 8'h1B;
   localparam logic [7:0] KEY_BRACKET  = 8'h5B;
   localparam logic [7:0] KEY_M        = 8'h6D;
   localparam logic [7:0] KEY_SPACE    = 8'h20;
   localparam logic [7:0] KEY_DIGIT_LO = 8'h30;
   localparam logic [7:0] KEY_DIGIT_HI = 8'h39;

   // Escape codes and the colours they select
   localparam logic [15:0] SGR_CODE_DEFAULT = 16'd0;
   localparam logic [15:0] SGR_CODE_RED     = 16'd31;
   localparam logic [15:0] SGR_CODE_GREEN   = 16'd32;
   localparam logic [3:0]  FG_RED           = 4'h4;
   localparam logic [3:0]  FG_GREEN         = 4'h2;

   // Attribute held by the default colour register out of reset
   localparam logic [7:0] BASE_ATTR_RST = 8'd7;

   typedef enum logic [1:0] {
      ACT_WRITE,
      ACT_READ,
      ACT_COLOR,
      ACT_CLEAR
   } action_type;

   typedef enum logic [1:0] {
      BK_NONE,
      BK_PUT,
      BK_NEWLINE,
      BK_SGR
   } byte_kind_type;

   typedef enum logic [1:0] {
      SGR_IGNORE,
      SGR_DEFAULT,
      SGR_RED,
      SGR_GREEN
   } sgr_type;

   // Decoded meaning of one stream byte, from the escape parser to the sequencer
   typedef struct packed {
      byte_kind_type kind;
      sgr_type       sgr;
   } esc_result_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

endpackage

### src/tterm_ram.sv
// Generic single-clock RAM: one write port, one read port, read data registered.
// No dependencies.
module tterm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/tterm_esc.sv
// Escape parser: holds the escape state and classifies each stream byte.
// Depends on tterm_pkg.
module tterm_esc (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               char_byte,
   output tterm_pkg::esc_result_type esc_result
);
   import tterm_pkg::*;

   logic        in_esc_ff, in_esc_in;
   logic [7:0]  step_ff, step_in;
   logic [15:0] value_ff, value_in;
   logic        is_digit;

   assign is_digit = (char_byte >= KEY_DIGIT_LO) && (char_byte <= KEY_DIGIT_HI);

   // Byte classification and escape state update
   always_comb begin
      in_esc_in       = in_esc_ff;
      step_in         = step_ff;
      value_in        = value_ff;
      esc_result.kind = BK_NONE;
      esc_result.sgr  = SGR_IGNORE;
      if (char_byte == KEY_NEWLINE) begin
         esc_result.kind = BK_NEWLINE;
      end else if (char_byte == KEY_ESC) begin
         in_esc_in = 1'b1;
         step_in   = 8'd1;
         value_in  = 16'd0;
      end else if (in_esc_ff) begin
         if ((char_byte == KEY_BRACKET) && (step_ff == 8'd1)) begin
            step_in = 8'd2;
         end else if (is_digit && (step_ff > 8'd1)) begin
            // 16-bit wrapping decimal accumulate
            value_in = value_ff * 16'd10 + {12'd0, char_byte[3:0]};
            step_in  = step_ff + 8'd1;
         end else if (char_byte == KEY_M) begin
            in_esc_in       = 1'b0;
            esc_result.kind = BK_SGR;
            if (value_ff == SGR_CODE_DEFAULT) begin
               esc_result.sgr = SGR_DEFAULT;
            end else if (value_ff == SGR_CODE_RED) begin
               esc_result.sgr = SGR_RED;
            end else if (value_ff == SGR_CODE_GREEN) begin
               esc_result.sgr = SGR_GREEN;
            end
         end else begin
            // anything else cancels the escape and is dropped
            in_esc_in = 1'b0;
         end
      end else begin
         esc_result.kind = BK_PUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_esc_ff <= 1'b0;
         step_ff   <= 8'd0;
         value_ff  <= 16'd0;
      end else if (byte_accept) begin
         in_esc_ff <= in_esc_in;
         step_ff   <= step_in;
         value_ff  <= value_in;
      end
   end

   // Escape state moves only on an accepted stream byte
   assert property (@(posedge clock) disable iff (reset)
      !byte_accept |=> $stable(in_esc_ff) && $stable(step_ff) && $stable(value_ff))
      else $error("escape state changed without a stream byte");

endmodule

### src/tterm_seq.sv
// Sequencer: cursor, colour, request decode and the walks over the cell store
// (clear, scroll copy, bottom row fill). Depends on tterm_pkg; drives tterm_ram.
module tterm_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = ROWS * COLUMNS,
   localparam int AW     = $clog2(CELLS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [7:0]                    req_char_byte,
   input  logic [4:0]                    req_read_row,
   input  logic [6:0]                    req_read_col,
   input  logic [3:0]                    req_fg_color,
   input  logic [3:0]                    req_bg_color,
   input  tterm_pkg::esc_result_type     esc_result,
   output logic                          byte_accept,
   input  logic [7:0]                    base_attr,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [tterm_pkg::CELL_W-1:0]  ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [tterm_pkg::CELL_W-1:0]  ram_rdata,
   output logic                          rsp_valid,
   output logic [tterm_pkg::CELL_W-1:0]  rsp_cell_data,
   output logic [tterm_pkg::ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [tterm_pkg::COL_PORT_W-1:0] rsp_cursor_col,
   output logic [7:0]                    rsp_current_color
);
   import tterm_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [AW-1:0] FIRST_SRC  = AW'(COLUMNS);
   localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

   state_type       state_ff, state_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pend_addr_ff, pend_addr_in;
   logic            rd_ok_ff, rd_ok_in;
   logic            clr_report_ff, clr_report_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [7:0]      color_ff, color_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [RW-1:0]   rsp_row_ff;
   logic [CW-1:0]   rsp_col_ff;
   logic [7:0]      rsp_color_ff;

   logic            accept;
   logic            done;
   logic            ptr_last;
   logic            row_last;
   logic            read_in_range;
   logic [AW-1:0]   cursor_addr;
   logic [AW-1:0]   read_addr;
   logic [CELL_W-1:0] blank_cell;
   action_type      action;

   assign action        = action_type'(req_action);
   assign ptr_last      = (ptr_ff == LAST_CELL);
   assign row_last      = (row_ff == LAST_ROW);
   assign cursor_addr   = AW'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign read_in_range = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLUMNS);
   assign read_addr     = read_in_range ?
                          AW'(int'(req_read_row) * COLUMNS + int'(req_read_col)) : '0;
   assign blank_cell    = {base_attr, KEY_SPACE};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_WRITE: begin
                     if ((esc_result.kind == BK_NEWLINE) && row_last) state_in = ST_SCROLL;
                  end
                  ACT_READ:  state_in = ST_READ;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_SCROLL: begin
            if (ptr_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (!pend_ff && ptr_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: store accesses, cursor and colour updates, result capture
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      accept        = start && (state_ff == ST_IDLE);
      byte_accept   = accept && (action == ACT_WRITE);
      ram_we        = 1'b0;
      ram_waddr     = cursor_addr;
      ram_wdata     = {color_ff, req_char_byte};
      ram_raddr     = ptr_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rd_ok_in      = rd_ok_ff;
      clr_report_in = clr_report_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      color_in      = color_ff;
      done          = 1'b0;
      cell_in       = '0;
      case (state_ff)
         ST_CLEAR: begin
            // the clearing pass out of reset uses the reset colour and reports nothing
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = clr_report_ff ? blank_cell : {BASE_ATTR_RST, KEY_SPACE};
            ptr_in    = ptr_ff + AW'(1);
            if (ptr_last) done = clr_report_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_WRITE: begin
                     case (esc_result.kind)
                        BK_PUT: begin
                           ram_we = 1'b1;
                           done   = 1'b1;
                           if (col_ff == LAST_COL) begin
                              col_in = '0;
                              row_in = row_last ? '0 : row_ff + RW'(1);
                           end else begin
                              col_in = col_ff + CW'(1);
                           end
                        end
                        BK_NEWLINE: begin
                           col_in = '0;
                           if (row_last) begin
                              ptr_in = FIRST_SRC;
                           end else begin
                              row_in = row_ff + RW'(1);
                              done   = 1'b1;
                           end
                        end
                        BK_SGR: begin
                           done = 1'b1;
                           case (esc_result.sgr)
                              SGR_DEFAULT: color_in = base_attr;
                              SGR_RED:     color_in = {color_ff[7:4], FG_RED};
                              SGR_GREEN:   color_in = {color_ff[7:4], FG_GREEN};
                              default:     color_in = color_ff;
                           endcase
                        end
                        default: done = 1'b1;
                     endcase
                  end
                  ACT_READ: begin
                     ram_raddr = read_addr;
                     rd_ok_in  = read_in_range;
                  end
                  ACT_COLOR: begin
                     color_in = {req_bg_color, req_fg_color};
                     done     = 1'b1;
                  end
                  default: begin
                     row_in        = '0;
                     col_in        = '0;
                     color_in      = base_attr;
                     ptr_in        = '0;
                     clr_report_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            done    = 1'b1;
            cell_in = rd_ok_ff ? ram_rdata : '0;
         end
         ST_SCROLL: begin
            // read one row down, write it back in the next cycle one row up
            ram_raddr    = ptr_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff - FIRST_SRC;
            ram_we       = pend_ff;
            ram_waddr    = pend_addr_ff;
            ram_wdata    = ram_rdata;
            ptr_in       = ptr_last ? BOTTOM_ROW : ptr_ff + AW'(1);
         end
         ST_FILL: begin
            ram_we = 1'b1;
            if (pend_ff) begin
               // last copy of the scroll still owes its write
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
            end else begin
               ram_waddr = ptr_ff;
               ram_wdata = blank_cell;
               ptr_in    = ptr_ff + AW'(1);
               done      = ptr_last;
            end
         end
         default: ;
      endcase
      rsp_valid_in = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         clr_report_ff <= 1'b0;
         rd_ok_ff      <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         color_ff      <= BASE_ATTR_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         clr_report_ff <= clr_report_in;
         rd_ok_ff      <= rd_ok_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         color_ff      <= color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload and scroll write address
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (done) begin
         cell_ff      <= cell_in;
         rsp_row_ff   <= row_in;
         rsp_col_ff   <= col_in;
         rsp_color_ff <= color_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_data     = cell_ff;
   assign rsp_cursor_row    = ROW_PORT_W'(rsp_row_ff);
   assign rsp_cursor_col    = COL_PORT_W'(rsp_col_ff);
   assign rsp_current_color = rsp_color_ff;

   // Cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS))
      else $error("cursor outside the screen");

   // A deferred copy write exists only during a scroll
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCROLL) || (state_ff == ST_FILL))
      else $error("copy write pending outside a scroll");

   // A cell read request is always answered by a result strobe after the read state
   assert property (@(posedge clock) disable iff (reset)
      (accept && (action == ACT_READ)) |-> ##2 rsp_valid_ff)
      else $error("cell read produced no result");

   // A strobe always follows a finishing step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(done))
      else $error("result strobe without a finished request");

endmodule

### src/text_terminal_with_sgr_escapes.sv
// Text terminal top level: request and configuration ports, cell store, parser, sequencer.
// Depends on tterm_pkg, tterm_ram, tterm_esc and tterm_seq.
//
// Character terminal over a ROWS x COLUMNS store of 16-bit cells (character in the low
// byte, attribute in the high byte), held in one single-port-write, registered-read RAM.
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown for one cycle with rsp_valid high, and the receiver cannot hold it off.
// Timing: a stream byte, a colour set or a newline that does not scroll gives its result
// in the cycle after the request and the next request can be taken then. A cell read
// passes through the registered RAM read and a read state before its result. A newline
// on the last row scrolls by copying the store one cell per cycle through the RAM ports
// and then filling the bottom row, busy all the while. A clear screen writes every cell
// once. After reset, busy stays high for a clearing pass over every cell; the user must
// write the default colour register through the csr port only between requests, while
// nothing is in flight. The block itself does not enforce this.
module text_terminal_with_sgr_escapes #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_byte,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   input  logic [3:0]  req_fg_color,
   input  logic [3:0]  req_bg_color,
   output logic        rsp_valid,
   output logic [15:0] rsp_cell_data,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   output logic [7:0]  rsp_current_color,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);
   import tterm_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]        base_attr_ff;
   esc_result_type    esc_result;
   logic              byte_accept;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_rdata;

   // Default colour register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_attr_ff <= BASE_ATTR_RST;
      end else if (csr_valid && csr_ready) begin
         base_attr_ff <= csr_wdata;
      end
   end

   // Cell store
   tterm_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Escape parser
   tterm_esc u_esc (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .char_byte   (req_char_byte),
      .esc_result  (esc_result)
   );

   // Sequencer
   tterm_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_char_byte     (req_char_byte),
      .req_read_row      (req_read_row),
      .req_read_col      (req_read_col),
      .req_fg_color      (req_fg_color),
      .req_bg_color      (req_bg_color),
      .esc_result        (esc_result),
      .byte_accept       (byte_accept),
      .base_attr         (base_attr_ff),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_current_color (rsp_current_color)
   );

endmodule
